>>> rtl/lsau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Load/store address unit package
// Item types, addressing mode codes and instruction bit positions.
// ----------------------------------------------------------------------------
package lsau_pkg;

  localparam int unsigned BitWide     = 30;
  localparam int unsigned BitLoad     = 22;
  localparam int unsigned BitUnsigned = 24;
  localparam int unsigned BitRegister = 21;
  localparam int unsigned BitPre      = 11;
  localparam int unsigned Imm19Width  = 19;
  localparam int unsigned Imm9Width   = 9;
  localparam int unsigned Imm12Width  = 12;

  typedef enum logic [2:0] {
    MODE_UNSIGNED = 3'd0,
    MODE_REGISTER = 3'd1,
    MODE_PRE      = 3'd2,
    MODE_POST     = 3'd3,
    MODE_LITERAL  = 3'd4
  } addr_mode_e;

  typedef struct packed {
    logic [31:0] instruction;
    logic [63:0] base_value;
    logic [63:0] index_value;
    logic [63:0] pc;
  } lsau_in_t;

  typedef struct packed {
    logic [63:0] mem_address;
    logic        is_load;
    logic        is_wide;
    logic [4:0]  target_reg;
    logic [4:0]  base_reg;
    logic [4:0]  index_reg;
    logic [2:0]  addr_mode;
    logic        base_writeback;
    logic [63:0] base_new_value;
  } lsau_out_t;

  typedef struct packed {
    logic [63:0] op_a;
    logic [63:0] op_b;
    logic        addr_is_base;
    logic        writeback;
    logic        is_load;
    logic        is_wide;
    logic [4:0]  target_reg;
    logic [4:0]  base_reg;
    logic [4:0]  index_reg;
    addr_mode_e  mode;
  } lsau_dec_t;

endpackage
`default_nettype wire

>>> rtl/load_store_address_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Load/store address unit
// Stages: decode, low-half add, high-half add into the output register,
// each registered in that order from input accept to output valid.
// Throughput: one item per cycle; each stage advances when the next is
// empty or advancing, so a stall backs up without loss.
// Reset: asynchronous, active low; clears the stage valid bits only.
// ----------------------------------------------------------------------------
module load_store_address_unit (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire lsau_pkg::lsau_in_t in_item_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output lsau_pkg::lsau_out_t     out_item_o
);
  import lsau_pkg::*;

  lsau_dec_t   dec;
  lsau_dec_t   s1_q;
  lsau_dec_t   s2_q;
  lsau_out_t   s3_d;
  lsau_out_t   s3_q;
  logic        v1_q, v2_q, v3_q;
  logic        adv1, adv2, adv3;
  logic [32:0] lo_sum;
  logic [31:0] lo_q;
  logic        carry_q;
  logic [31:0] hi_sum;
  logic [63:0] sum;

  lsau_decode u_decode (
    .item_i (in_item_i),
    .dec_o  (dec)
  );

  assign adv3       = !v3_q || !out_stall_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;

  assign lo_sum = {1'b0, s1_q.op_a[31:0]} + {1'b0, s1_q.op_b[31:0]};
  assign hi_sum = s2_q.op_a[63:32] + s2_q.op_b[63:32] + {31'd0, carry_q};
  assign sum    = {hi_sum, lo_q};

  always_comb begin
    s3_d                = '0;
    s3_d.mem_address    = s2_q.addr_is_base ? s2_q.op_a : sum;
    s3_d.is_load        = s2_q.is_load;
    s3_d.is_wide        = s2_q.is_wide;
    s3_d.target_reg     = s2_q.target_reg;
    s3_d.base_reg       = s2_q.base_reg;
    s3_d.index_reg      = s2_q.index_reg;
    s3_d.addr_mode      = s2_q.mode;
    s3_d.base_writeback = s2_q.writeback;
    s3_d.base_new_value = s2_q.writeback ? sum : 64'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) s1_q <= dec;
    if (adv2 && v1_q) begin
      s2_q    <= s1_q;
      lo_q    <= lo_sum[31:0];
      carry_q <= lo_sum[32];
    end
    if (adv3 && v2_q) s3_q <= s3_d;
  end

  assign out_valid_o = v3_q;
  assign out_item_o  = s3_q;

endmodule
`default_nettype wire

>>> rtl/lsau_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Load/store address unit decoder
// Picks the addressing mode and the two adder operands from one item.
// ----------------------------------------------------------------------------
module lsau_decode (
  input  wire lsau_pkg::lsau_in_t item_i,
  output lsau_pkg::lsau_dec_t     dec_o
);
  import lsau_pkg::*;

  logic [31:0]           insn;
  logic [Imm19Width-1:0] imm19;
  logic [Imm9Width-1:0]  imm9;
  logic [Imm12Width-1:0] imm12;
  logic [63:0]           lit_off;
  logic [63:0]           simm9;
  logic [63:0]           uoff;

  assign insn    = item_i.instruction;
  assign imm19   = insn[23:5];
  assign imm9    = insn[20:12];
  assign imm12   = insn[21:10];
  assign lit_off = {{(64-Imm19Width-2){imm19[Imm19Width-1]}}, imm19, 2'b00};
  assign simm9   = {{(64-Imm9Width){imm9[Imm9Width-1]}}, imm9};
  assign uoff    = insn[BitWide] ? {{(64-Imm12Width-3){1'b0}}, imm12, 3'b000}
                                 : {{(64-Imm12Width-2){1'b0}}, imm12, 2'b00};

  always_comb begin
    dec_o              = '0;
    dec_o.is_wide      = insn[BitWide];
    dec_o.target_reg   = insn[4:0];
    dec_o.op_a         = item_i.base_value;
    dec_o.op_b         = uoff;
    dec_o.mode         = MODE_UNSIGNED;
    if (!insn[31]) begin
      dec_o.op_a    = item_i.pc;
      dec_o.op_b    = lit_off;
      dec_o.is_load = 1'b1;
      dec_o.mode    = MODE_LITERAL;
    end else begin
      dec_o.is_load  = insn[BitLoad];
      dec_o.base_reg = insn[9:5];
      priority if (insn[BitUnsigned]) begin
        dec_o.mode = MODE_UNSIGNED;
      end else if (insn[BitRegister]) begin
        dec_o.op_b      = item_i.index_value;
        dec_o.index_reg = insn[20:16];
        dec_o.mode      = MODE_REGISTER;
      end else if (insn[BitPre]) begin
        dec_o.op_b      = simm9;
        dec_o.writeback = 1'b1;
        dec_o.mode      = MODE_PRE;
      end else begin
        dec_o.op_b         = simm9;
        dec_o.writeback    = 1'b1;
        dec_o.addr_is_base = 1'b1;
        dec_o.mode         = MODE_POST;
      end
    end
  end

endmodule
`default_nettype wire
